// ----- src/ctok_pkg.sv -----
package ctok_pkg;

    localparam int POS_WIDTH = 16;
    localparam int OUT_W     = 16;
    localparam int EXT_W     = (POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W;
    localparam int QDEPTH    = 4;
    localparam int COUNT_W   = $clog2(QDEPTH + 1);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [EXT_W-1:0]     OUT_MAX = EXT_W'({OUT_W{1'b1}});

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;

    typedef enum logic [4:0] {
        KIND_ID      = 5'd0,
        KIND_INT     = 5'd1,
        KIND_PIPE    = 5'd2,
        KIND_OROR    = 5'd3,
        KIND_AMP     = 5'd4,
        KIND_ANDAND  = 5'd5,
        KIND_EQ      = 5'd6,
        KIND_EQEQ    = 5'd7,
        KIND_NOT     = 5'd8,
        KIND_NE      = 5'd9,
        KIND_LT      = 5'd10,
        KIND_LE      = 5'd11,
        KIND_LPAREN  = 5'd12,
        KIND_RPAREN  = 5'd13,
        KIND_LBRACE  = 5'd14,
        KIND_RBRACE  = 5'd15,
        KIND_COLON   = 5'd16,
        KIND_SEMI    = 5'd17,
        KIND_COMMA   = 5'd18,
        KIND_HASH    = 5'd19,
        KIND_PLUS    = 5'd20,
        KIND_STAR    = 5'd21,
        KIND_MINUS   = 5'd22,
        KIND_PERCENT = 5'd23,
        KIND_SLASH   = 5'd24,
        KIND_EOF     = 5'd25,
        KIND_ERROR   = 5'd26
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_ID   = 4'b0010,
        MODE_NUM  = 4'b0100,
        MODE_OP   = 4'b1000
    } t_mode;

    typedef struct packed {
        t_kind             kind;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  len;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    res_a;
        t_result    res_b;
    } t_push;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {CH_CR, CH_LF, CH_SPACE, CH_TAB});
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c inside {CH_PIPE, CH_AMP, CH_EQ, CH_BANG, CH_LT});
    endfunction

    function automatic t_kind op_kind(input logic [7:0] c, input logic pair);
        t_kind k;
        case (c)
            CH_PIPE: k = pair ? KIND_OROR : KIND_PIPE;
            CH_AMP:  k = pair ? KIND_ANDAND : KIND_AMP;
            CH_EQ:   k = pair ? KIND_EQEQ : KIND_EQ;
            CH_BANG: k = pair ? KIND_NE : KIND_NOT;
            default: k = pair ? KIND_LE : KIND_LT;
        endcase
        return k;
    endfunction

    function automatic logic completes_pair(input logic [7:0] first, input logic [7:0] second);
        logic ok;
        case (first)
            CH_PIPE, CH_AMP, CH_EQ: ok = (second == first);
            CH_BANG, CH_LT:         ok = (second == CH_EQ);
            default:                ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c inside {"(", ")", "{", "}", ":", ";", ",", "#", "+", "*", "-", "%", "/"});
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ":":     k = KIND_COLON;
            ";":     k = KIND_SEMI;
            ",":     k = KIND_COMMA;
            "#":     k = KIND_HASH;
            "+":     k = KIND_PLUS;
            "*":     k = KIND_STAR;
            "-":     k = KIND_MINUS;
            "%":     k = KIND_PERCENT;
            "/":     k = KIND_SLASH;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input logic [POS_WIDTH-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > OUT_MAX) begin
            return {OUT_W{1'b1}};
        end
        return e[OUT_W-1:0];
    endfunction

    function automatic t_result mk_result(
        input t_kind                kind,
        input logic [POS_WIDTH-1:0] start,
        input logic [POS_WIDTH-1:0] len
    );
        t_result r;
        r.kind  = kind;
        r.start = clamp_out(start);
        r.len   = clamp_out(len);
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/ctok_lex.sv -----
module ctok_lex (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_ch,
    output ctok_pkg::t_push  o_push
);
    import ctok_pkg::*;

    t_mode                r_mode, n_mode;
    logic [7:0]           r_pend, n_pend;
    logic [POS_WIDTH-1:0] r_start, n_start;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic                 r_err, n_err;

    logic [POS_WIDTH-1:0] pos_inc;
    logic [POS_WIDTH-1:0] span;
    logic                 done;
    logic                 flush_v, own_v;
    t_result              flush_r, own_r;

    assign pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign span    = (r_pos >= r_start) ? r_pos - r_start : '0;

    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_start = r_start;
        n_pos   = r_pos;
        n_err   = r_err;
        done    = 1'b0;
        flush_v = 1'b0;
        own_v   = 1'b0;
        flush_r = '0;
        own_r   = '0;

        if (r_err) begin
            done = 1'b1;
            if (i_ch == CH_NUL) begin
                own_v   = 1'b1;
                own_r   = mk_result(KIND_EOF, r_pos, '0);
                n_mode  = MODE_IDLE;
                n_pend  = '0;
                n_start = '0;
                n_pos   = '0;
                n_err   = 1'b0;
            end else begin
                n_pos = pos_inc;
            end
        end else begin
            case (r_mode)
                MODE_ID: begin
                    if (is_letter(i_ch) || is_digit(i_ch)) begin
                        n_pos = pos_inc;
                        done  = 1'b1;
                    end else begin
                        flush_v = 1'b1;
                        flush_r = mk_result(KIND_ID, r_start, span);
                        n_mode  = MODE_IDLE;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(i_ch)) begin
                        n_pos = pos_inc;
                        done  = 1'b1;
                    end else begin
                        flush_v = 1'b1;
                        flush_r = mk_result(KIND_INT, r_start, span);
                        n_mode  = MODE_IDLE;
                    end
                end
                MODE_OP: begin
                    flush_v = 1'b1;
                    n_mode  = MODE_IDLE;
                    n_pend  = '0;
                    if (completes_pair(r_pend, i_ch)) begin
                        flush_r = mk_result(op_kind(r_pend, 1'b1), r_start, POS_WIDTH'(2));
                        n_pos   = pos_inc;
                        done    = 1'b1;
                    end else begin
                        flush_r = mk_result(op_kind(r_pend, 1'b0), r_start, POS_WIDTH'(1));
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase

            if (!done) begin
                if (i_ch == CH_NUL) begin
                    own_v   = 1'b1;
                    own_r   = mk_result(KIND_EOF, r_pos, '0);
                    n_mode  = MODE_IDLE;
                    n_pend  = '0;
                    n_start = '0;
                    n_pos   = '0;
                    n_err   = 1'b0;
                end else if (is_space(i_ch)) begin
                    n_pos = pos_inc;
                end else if (is_letter(i_ch)) begin
                    n_mode  = MODE_ID;
                    n_start = r_pos;
                    n_pos   = pos_inc;
                end else if (is_digit(i_ch)) begin
                    n_mode  = MODE_NUM;
                    n_start = r_pos;
                    n_pos   = pos_inc;
                end else if (is_op(i_ch)) begin
                    n_mode  = MODE_OP;
                    n_pend  = i_ch;
                    n_start = r_pos;
                    n_pos   = pos_inc;
                end else begin
                    own_v = 1'b1;
                    if (is_punct(i_ch)) begin
                        own_r = mk_result(punct_kind(i_ch), r_pos, POS_WIDTH'(1));
                    end else begin
                        own_r = mk_result(KIND_ERROR, r_pos, POS_WIDTH'(1));
                        n_err = 1'b1;
                    end
                    n_pos = pos_inc;
                end
            end
        end
    end

    always_comb begin
        o_push = '0;
        if (i_accept) begin
            if (flush_v && own_v) begin
                o_push.n     = 2'd2;
                o_push.res_a = flush_r;
                o_push.res_b = own_r;
                o_push.res_b.last = 1'b1;
            end else if (flush_v || own_v) begin
                o_push.n     = 2'd1;
                o_push.res_a = flush_v ? flush_r : own_r;
                o_push.res_a.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_err   <= n_err;
        end
    end

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_mode == MODE_IDLE))
        else $error("error hold with a token in progress");

    a_pend_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OP) == (r_pend != '0))
        else $error("held operator byte out of step with scan mode");

    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_pos)
        else $error("token start beyond current position");

endmodule

// ----- src/ctok_rq.sv -----
module ctok_rq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctok_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_ready,
    output ctok_pkg::t_result o_head
);
    import ctok_pkg::*;

    t_result              r_q [QDEPTH];
    t_result              n_q [QDEPTH];
    t_result              shifted [QDEPTH];
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [COUNT_W-1:0]   cnt_after;

    assign o_valid   = (r_count != '0);
    assign o_ready   = (r_count <= COUNT_W'(QDEPTH - 2));
    assign o_head    = r_q[0];
    assign cnt_after = r_count - COUNT_W'(i_pop);
    assign n_count   = cnt_after + COUNT_W'(i_push.n);

    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            shifted[i] = i_pop ? r_q[i+1] : r_q[i];
        end
        shifted[QDEPTH-1] = r_q[QDEPTH-1];
        for (int i = 0; i < QDEPTH; i++) begin
            if (COUNT_W'(i) < cnt_after) begin
                n_q[i] = shifted[i];
            end else if (COUNT_W'(i) == cnt_after && i_push.n != 2'd0) begin
                n_q[i] = i_push.res_a;
            end else if (COUNT_W'(i) == cnt_after + 1'b1 && i_push.n == 2'd2) begin
                n_q[i] = i_push.res_b;
            end else begin
                n_q[i] = r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> o_ready)
        else $error("results pushed without room");

endmodule

// ----- src/c_like_tokenizer.sv -----
// Channel  Handshake            Payload
// in       i_valid / o_ready    i_ch
// out      o_valid / i_ready    o_token_kind, o_start_pos, o_token_len, o_last
//
// A byte is classified and the scan state updated in the cycle it is accepted.
// Its zero, one or two tokens enter a four-entry result queue and show at the
// output from the next cycle on, one token per cycle while i_ready is high.
// One byte per cycle is taken while the queue holds at most two tokens.
// Reset is synchronous and clears the scan state and the queue.
// A stalled output only stops input once the queue has three or more tokens.
module c_like_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_start_pos,
    output logic [15:0] o_token_len,
    output logic        o_last
);
    import ctok_pkg::*;

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = i_valid && o_ready;

    ctok_lex u_lex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_ch),
        .o_push   (push)
    );

    ctok_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_valid && i_ready),
        .o_valid (o_valid),
        .o_ready (o_ready),
        .o_head  (head)
    );

    assign o_token_kind = head.kind;
    assign o_start_pos  = head.start;
    assign o_token_len  = head.len;
    assign o_last       = head.last;

endmodule
